/* sv/page_run_free_list_allocator_defines.svh */
// ---------------------------------------------------------------------------
// Page-run allocator assertion macros
// Concurrent checks on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef PAGE_RUN_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PAGE_RUN_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// expr must hold at every edge
`define PFA_ASSERT_HOLD(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("pfa: invariant violated");
// ante at one edge implies cons at the next
`define PFA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pfa: sequence violated");
`else
`define PFA_ASSERT_HOLD(lbl, expr)
`define PFA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/pfa_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page-run allocator package
// Item types, action codes, sequencer states and counter constants.
// ---------------------------------------------------------------------------
package pfa_pkg;

   localparam int PAGE_FRAMES_DEF = 65536;
   localparam int COUNT_W         = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;

   localparam logic [2:0] ACT_ADD         = 3'd0;
   localparam logic [2:0] ACT_ALLOC       = 3'd1;
   localparam logic [2:0] ACT_ALLOC_CHECK = 3'd2;
   localparam logic [2:0] ACT_FREE        = 3'd3;
   localparam logic [2:0] ACT_FREE_CREDIT = 3'd4;
   localparam logic [2:0] ACT_RESERVE     = 3'd5;
   localparam logic [2:0] ACT_UNRESERVE   = 3'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_COUNT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SEL_TOTAL,
      SEL_AVAIL,
      SEL_FREE
   } cnt_sel_type;

   typedef enum logic [1:0] {
      CNT_NONE,
      CNT_ADD,
      CNT_SUB
   } cnt_op_type;

   typedef struct packed {
      logic [2:0]         action;
      logic [15:0]        page_number;
      logic [COUNT_W-1:0] page_count;
   } req_type;

   typedef struct packed {
      logic [15:0]        granted_page;
      logic               ok;
      logic [COUNT_W-1:0] free_pages_now;
      logic [COUNT_W-1:0] avail_pages_now;
      logic [COUNT_W-1:0] total_pages_now;
   } rsp_type;

endpackage

/* sv/pfa_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/pfa_sat_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Saturating counter unit
// Shared add / subtract for the page counters; a subtract that would go
// below zero is refused and leaves the counter as it is.
// ---------------------------------------------------------------------------
module pfa_sat_unit #(
   parameter int DELTA_W = 17
) (
   input  pfa_pkg::cnt_op_type           op,
   input  logic [pfa_pkg::COUNT_W-1:0]   base,
   input  logic [DELTA_W-1:0]            delta,
   output logic [pfa_pkg::COUNT_W-1:0]   result,
   output logic                          refused
);

   logic [DELTA_W:0] base_wide;
   logic [DELTA_W:0] delta_wide;
   logic [DELTA_W:0] sum_wide;
   logic [DELTA_W:0] diff_wide;

   assign base_wide  = (DELTA_W+1)'(base);
   assign delta_wide = (DELTA_W+1)'(delta);
   assign sum_wide   = base_wide + delta_wide;
   assign diff_wide  = base_wide - delta_wide;

   always_comb begin
      result  = base;
      refused = 1'b0;
      unique case (op)
         pfa_pkg::CNT_ADD: begin
            if (sum_wide > (DELTA_W+1)'(pfa_pkg::COUNT_MAX)) begin
               result = pfa_pkg::COUNT_MAX;
            end else begin
               result = pfa_pkg::COUNT_W'(sum_wide);
            end
         end
         pfa_pkg::CNT_SUB: begin
            // a decrement by one at zero lands here too, which is the floor
            if (delta_wide > base_wide) begin
               refused = 1'b1;
            end else begin
               result = pfa_pkg::COUNT_W'(diff_wide);
            end
         end
         default: begin
            result = base;
         end
      endcase
   end

endmodule

/* sv/page_run_free_list_allocator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Page-run free-list allocator
// LIFO list of free page runs kept in one RAM, with saturating page counters.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one action item (add region, alloc, alloc checked, free, free
//            credited, reserve, unreserve) under valid/ready.
//   rsp_*  : exactly one result item per request: granted page, ok flag and
//            the free, available and total page counts after the action.
// Flow: one item at a time, taken only in the idle state. An item reads
//   the head run entry (one registered RAM read), writes the run RAM as its
//   action needs (an alloc writes the head entry back), then passes the
//   three counters one per cycle through the single saturating counter unit.
// Reset: the list is empty and all counters are zero; the run RAM is not
//   cleared, since the list never reaches an entry that was not written.
// Stall: a result held by rsp_ready low sits in the output register; the
//   next request is still taken and worked, and its result waits until the
//   output register frees up.
// ---------------------------------------------------------------------------
`include "page_run_free_list_allocator_defines.svh"

module page_run_free_list_allocator #(
   parameter int PAGE_FRAMES = pfa_pkg::PAGE_FRAMES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pfa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pfa_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(PAGE_FRAMES);
   localparam int HW = AW + 1;
   localparam int LW = AW + 1;
   localparam int DW = (LW > pfa_pkg::COUNT_W) ? LW : pfa_pkg::COUNT_W;
   localparam logic [HW-1:0] EMPTY = HW'(PAGE_FRAMES);

   pfa_pkg::state_type   state_ff, state_in;
   pfa_pkg::cnt_sel_type sel_ff, sel_in;
   pfa_pkg::req_type     item_ff, item_in;
   logic [HW-1:0]        head_ff, head_in;
   logic [pfa_pkg::COUNT_W-1:0] total_ff, total_in;
   logic [pfa_pkg::COUNT_W-1:0] avail_ff, avail_in;
   logic [pfa_pkg::COUNT_W-1:0] free_ff, free_in;
   pfa_pkg::cnt_op_type  op_total_ff, op_total_in;
   pfa_pkg::cnt_op_type  op_avail_ff, op_avail_in;
   pfa_pkg::cnt_op_type  op_free_ff, op_free_in;
   logic [DW-1:0]        delta_ff, delta_in;
   logic                 ok_ff, ok_in;
   logic [15:0]          granted_ff, granted_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pfa_pkg::rsp_type     rsp_ff, rsp_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [HW+LW-1:0]     ram_wdata;
   logic                 ram_re;
   logic [AW-1:0]        ram_raddr;
   logic [HW+LW-1:0]     ram_rdata;

   pfa_pkg::cnt_op_type         unit_op;
   logic [pfa_pkg::COUNT_W-1:0] unit_base;
   logic [pfa_pkg::COUNT_W-1:0] unit_result;
   logic                        unit_refused;

   logic                 page_ok;
   logic [AW-1:0]        page_addr;
   logic [LW-1:0]        room;
   logic [LW-1:0]        add_len;
   logic [HW-1:0]        rd_next;
   logic [LW-1:0]        rd_len;
   logic [LW-1:0]        new_len;
   logic                 head_live;
   logic                 alloc_gate;
   logic [AW-1:0]        grant_sum;

   pfa_ram #(
      .WIDTH(HW + LW),
      .DEPTH(PAGE_FRAMES)
   ) u_run_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pfa_sat_unit #(
      .DELTA_W(DW)
   ) u_sat (
      .op      (unit_op),
      .base    (unit_base),
      .delta   (delta_ff),
      .result  (unit_result),
      .refused (unit_refused)
   );

   assign page_ok   = 32'(item_ff.page_number) < 32'(PAGE_FRAMES);
   assign page_addr = AW'(item_ff.page_number);
   assign room      = LW'(PAGE_FRAMES) - LW'(item_ff.page_number);
   // region past the end is clipped to the remaining frames
   assign add_len   = (DW'(item_ff.page_count) > DW'(room)) ? room
                                                             : LW'(item_ff.page_count);
   assign rd_next   = ram_rdata[HW+LW-1:LW];
   assign rd_len    = ram_rdata[LW-1:0];
   assign new_len   = rd_len - LW'(1);
   assign head_live = head_ff < EMPTY;
   assign alloc_gate = (item_ff.action != pfa_pkg::ACT_ALLOC_CHECK) || (avail_ff != '0);
   assign grant_sum = head_ff[AW-1:0] + AW'(new_len);

   // counter pass: one counter through the shared unit per cycle
   always_comb begin
      unit_op   = pfa_pkg::CNT_NONE;
      unit_base = total_ff;
      if (state_ff == pfa_pkg::ST_COUNT) begin
         unique case (sel_ff)
            pfa_pkg::SEL_TOTAL: begin
               unit_op   = op_total_ff;
               unit_base = total_ff;
            end
            pfa_pkg::SEL_AVAIL: begin
               unit_op   = op_avail_ff;
               unit_base = avail_ff;
            end
            pfa_pkg::SEL_FREE: begin
               unit_op   = op_free_ff;
               unit_base = free_ff;
            end
            default: begin
               unit_op   = pfa_pkg::CNT_NONE;
               unit_base = total_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfa_pkg::ST_IDLE;
         sel_ff       <= pfa_pkg::SEL_TOTAL;
         head_ff      <= EMPTY;
         total_ff     <= '0;
         avail_ff     <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         avail_ff     <= avail_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      op_total_ff <= op_total_in;
      op_avail_ff <= op_avail_in;
      op_free_ff  <= op_free_in;
      delta_ff    <= delta_in;
      ok_ff       <= ok_in;
      granted_ff  <= granted_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      item_in      = item_ff;
      head_in      = head_ff;
      total_in     = total_ff;
      avail_in     = avail_ff;
      free_in      = free_ff;
      op_total_in  = op_total_ff;
      op_avail_in  = op_avail_ff;
      op_free_in   = op_free_ff;
      delta_in     = delta_ff;
      ok_in        = ok_ff;
      granted_in   = granted_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = page_addr;
      ram_wdata    = {head_ff, LW'(1)};
      ram_re       = 1'b0;
      ram_raddr    = head_ff[AW-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         pfa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_data;
               ram_re   = 1'b1;
               state_in = pfa_pkg::ST_APPLY;
            end
         end
         pfa_pkg::ST_APPLY: begin
            ok_in       = 1'b0;
            granted_in  = '0;
            op_total_in = pfa_pkg::CNT_NONE;
            op_avail_in = pfa_pkg::CNT_NONE;
            op_free_in  = pfa_pkg::CNT_NONE;
            delta_in    = DW'(1);
            unique case (item_ff.action) inside
               pfa_pkg::ACT_ADD: begin
                  if (page_ok && (item_ff.page_count != '0)) begin
                     ram_we      = 1'b1;
                     ram_wdata   = {head_ff, add_len};
                     head_in     = HW'(item_ff.page_number);
                     delta_in    = DW'(add_len);
                     op_total_in = pfa_pkg::CNT_ADD;
                     op_avail_in = pfa_pkg::CNT_ADD;
                     op_free_in  = pfa_pkg::CNT_ADD;
                     ok_in       = 1'b1;
                  end
               end
               pfa_pkg::ACT_ALLOC, pfa_pkg::ACT_ALLOC_CHECK: begin
                  if (alloc_gate && head_live) begin
                     if (rd_len == '0) begin
                        // zero-length run left by a double free: drop it, fail
                        head_in = rd_next;
                     end else begin
                        ram_we     = 1'b1;
                        ram_waddr  = head_ff[AW-1:0];
                        ram_wdata  = {rd_next, new_len};
                        if (new_len == '0) begin
                           head_in = rd_next;
                        end
                        granted_in = 16'(grant_sum);
                        op_free_in = pfa_pkg::CNT_SUB;
                        if (item_ff.action == pfa_pkg::ACT_ALLOC_CHECK) begin
                           op_avail_in = pfa_pkg::CNT_SUB;
                        end
                        ok_in      = 1'b1;
                     end
                  end
               end
               pfa_pkg::ACT_FREE, pfa_pkg::ACT_FREE_CREDIT: begin
                  if (page_ok) begin
                     ram_we     = 1'b1;
                     ram_wdata  = {head_ff, LW'(1)};
                     head_in    = HW'(item_ff.page_number);
                     op_free_in = pfa_pkg::CNT_ADD;
                     if (item_ff.action == pfa_pkg::ACT_FREE_CREDIT) begin
                        op_avail_in = pfa_pkg::CNT_ADD;
                     end
                     ok_in      = 1'b1;
                  end
               end
               pfa_pkg::ACT_RESERVE: begin
                  // ok settled by the unit during the avail step
                  delta_in    = DW'(item_ff.page_count);
                  op_avail_in = pfa_pkg::CNT_SUB;
               end
               pfa_pkg::ACT_UNRESERVE: begin
                  delta_in    = DW'(item_ff.page_count);
                  op_avail_in = pfa_pkg::CNT_ADD;
                  ok_in       = 1'b1;
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
            sel_in   = pfa_pkg::SEL_TOTAL;
            state_in = pfa_pkg::ST_COUNT;
         end
         pfa_pkg::ST_COUNT: begin
            unique case (sel_ff)
               pfa_pkg::SEL_TOTAL: begin
                  total_in = unit_result;
                  sel_in   = pfa_pkg::SEL_AVAIL;
               end
               pfa_pkg::SEL_AVAIL: begin
                  avail_in = unit_result;
                  if (item_ff.action == pfa_pkg::ACT_RESERVE) begin
                     ok_in = !unit_refused;
                  end
                  sel_in   = pfa_pkg::SEL_FREE;
               end
               pfa_pkg::SEL_FREE: begin
                  free_in  = unit_result;
                  sel_in   = pfa_pkg::SEL_TOTAL;
                  state_in = pfa_pkg::ST_DONE;
               end
               default: begin
                  sel_in   = pfa_pkg::SEL_TOTAL;
                  state_in = pfa_pkg::ST_DONE;
               end
            endcase
         end
         pfa_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_in.granted_page    = granted_ff;
               rsp_in.ok              = ok_ff;
               rsp_in.free_pages_now  = free_ff;
               rsp_in.avail_pages_now = avail_ff;
               rsp_in.total_pages_now = total_ff;
               state_in               = pfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pfa_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PFA_ASSERT_NEXT(a_accept_to_apply, req_valid && req_ready, state_ff == pfa_pkg::ST_APPLY)
   `PFA_ASSERT_HOLD(a_ram_write_in_apply, !ram_we || (state_ff == pfa_pkg::ST_APPLY))
   `PFA_ASSERT_HOLD(a_head_in_range, head_ff <= EMPTY)
   `PFA_ASSERT_NEXT(a_free_only_in_count, state_ff != pfa_pkg::ST_COUNT, $stable(free_ff))
   `PFA_ASSERT_NEXT(a_done_loads_rsp, (state_ff == pfa_pkg::ST_DONE) && !rsp_valid_ff, rsp_valid_ff)

endmodule
